// ===== rtl/tpc_pkg.sv =====
// Shared types and constants for the toolpath point transform and centroid block.
// No dependencies; every other rtl file but tpc_fifo refers to this package by scoped names.
`default_nettype none
package tpc_pkg;

   localparam int RAW_W      = 32;
   localparam int SCALE_W    = 32;
   localparam int ORIGIN_W   = 20;
   localparam int OUT_W      = 20;
   localparam int AREA_W     = 48;
   localparam int MOM_W      = 64;
   localparam int DIVISOR_W  = AREA_W + 2;
   localparam int DIV_CNT_W  = $clog2(MOM_W);
   localparam int CSR_IDX_W  = 4;
   localparam int CSR_DATA_W = 32;

   localparam logic [CSR_IDX_W-1:0] CSR_SCALE_X  = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] CSR_SCALE_Y  = CSR_IDX_W'(1);
   localparam logic [CSR_IDX_W-1:0] CSR_ORIGIN_X = CSR_IDX_W'(2);
   localparam logic [CSR_IDX_W-1:0] CSR_ORIGIN_Y = CSR_IDX_W'(3);

   typedef struct packed {
      logic signed [RAW_W-1:0] raw_x;
      logic signed [RAW_W-1:0] raw_y;
      logic                    line_start;
      logic                    sample_end;
   } req_payload_type;

   typedef struct packed {
      logic signed [OUT_W-1:0]  centroid_x;
      logic signed [OUT_W-1:0]  centroid_y;
      logic signed [AREA_W-1:0] twice_area;
      logic                     degenerate;
      logic                     saturated;
   } rsp_payload_type;

   typedef struct packed {
      logic [SCALE_W-1:0]         scale_x;
      logic [SCALE_W-1:0]         scale_y;
      logic signed [ORIGIN_W-1:0] origin_x;
      logic signed [ORIGIN_W-1:0] origin_y;
   } cfg_type;

   typedef struct packed {
      logic             done;
      logic             neg;
      logic [MOM_W-1:0] magnitude;
   } div_result_type;

   typedef enum logic [1:0] {
      FRONT_IDLE,
      FRONT_MUL,
      FRONT_DONE
   } front_state_type;

   typedef enum logic [3:0] {
      BACK_IDLE,
      BACK_CROSS,
      BACK_AREA,
      BACK_MOM,
      BACK_ACC,
      BACK_DIVX,
      BACK_WAITX,
      BACK_DIVY,
      BACK_WAITY,
      BACK_OUT
   } back_state_type;

endpackage
`default_nettype wire

// ===== rtl/tpc_fifo.sv =====
// Small first-in first-out queue with the head shown combinationally.
// No package dependency; used for the point queue and the result queue.
`default_nettype none
module tpc_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push,
   input  wire logic [WIDTH-1:0] din,
   output logic                  full,
   input  wire logic             pop,
   output logic [WIDTH-1:0]      dout,
   output logic                  empty
);
   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [CNT_W-1:0] count_ff;
   logic             do_push, do_pop;

   assign full    = (count_ff == CNT_W'(DEPTH));
   assign empty   = (count_ff == '0);
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign dout    = mem[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem[wr_ptr_ff] <= din;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (do_push) begin
            wr_ptr_ff <= (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
         end
         if (do_pop) begin
            rd_ptr_ff <= (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
         end
         if (do_push && !do_pop) begin
            count_ff <= count_ff + 1'b1;
         end else if (do_pop && !do_push) begin
            count_ff <= count_ff - 1'b1;
         end
      end
   end
endmodule
`default_nettype wire

// ===== rtl/tpc_front.sv =====
// Front end: takes raw points, scales, rounds, offsets and clamps them.
// Depends on tpc_pkg; feeds the point queue.
`default_nettype none
module tpc_front #(
   parameter int COORD_WIDTH     = 20,
   parameter int SCALE_FRAC_BITS = 24
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     req_push,
   output logic                          req_full,
   input  wire tpc_pkg::req_payload_type req_data,
   input  wire tpc_pkg::cfg_type         cfg,
   input  wire logic                     q_full,
   output logic                          q_push,
   output logic [2*COORD_WIDTH+2:0]      q_data
);
   localparam int SH = SCALE_FRAC_BITS - 8;
   localparam logic signed [65:0] HALF =
      (SCALE_FRAC_BITS > 8) ? (66'sd1 <<< ((SCALE_FRAC_BITS > 8) ? SCALE_FRAC_BITS - 9 : 0))
                            : 66'sd0;
   localparam logic signed [65:0] CLAMP_HI = (66'sd1 <<< (COORD_WIDTH - 1)) - 66'sd1;
   localparam logic signed [65:0] CLAMP_LO = -CLAMP_HI - 66'sd1;

   tpc_pkg::front_state_type state_ff, state_in;
   logic signed [tpc_pkg::RAW_W-1:0] raw_x_ff, raw_y_ff;
   logic                             ls_ff, se_ff;
   logic signed [64:0]               prod_x_ff, prod_y_ff;
   logic [COORD_WIDTH:0]             fin_x, fin_y;

   // round half up, add origin, clamp; top bit of the result is the clamp flag
   function automatic logic [COORD_WIDTH:0] finish(input logic signed [64:0] prod,
                                                   input logic signed [19:0] org);
      logic signed [65:0] rnd;
      logic signed [65:0] v;
      logic               sat;
      rnd = (66'(prod) + HALF) >>> SH;
      v   = rnd + 66'(org);
      sat = 1'b0;
      if (v > CLAMP_HI) begin
         v   = CLAMP_HI;
         sat = 1'b1;
      end else if (v < CLAMP_LO) begin
         v   = CLAMP_LO;
         sat = 1'b1;
      end
      return {sat, v[COORD_WIDTH-1:0]};
   endfunction

   assign fin_x  = finish(prod_x_ff, cfg.origin_x);
   assign fin_y  = finish(prod_y_ff, cfg.origin_y);
   assign q_data = {ls_ff, se_ff, fin_x[COORD_WIDTH] | fin_y[COORD_WIDTH],
                    fin_y[COORD_WIDTH-1:0], fin_x[COORD_WIDTH-1:0]};

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= tpc_pkg::FRONT_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == tpc_pkg::FRONT_IDLE && req_push) begin
         raw_x_ff <= req_data.raw_x;
         raw_y_ff <= req_data.raw_y;
         ls_ff    <= req_data.line_start;
         se_ff    <= req_data.sample_end;
      end
      if (state_ff == tpc_pkg::FRONT_MUL) begin
         prod_x_ff <= raw_x_ff * signed'({1'b0, cfg.scale_x});
         prod_y_ff <= raw_y_ff * signed'({1'b0, cfg.scale_y});
      end
   end

   always_comb begin
      state_in = state_ff;
      req_full = 1'b1;
      q_push   = 1'b0;
      case (state_ff)
         tpc_pkg::FRONT_IDLE: begin
            req_full = 1'b0;
            if (req_push) begin
               state_in = tpc_pkg::FRONT_MUL;
            end
         end
         tpc_pkg::FRONT_MUL: begin
            state_in = tpc_pkg::FRONT_DONE;
         end
         tpc_pkg::FRONT_DONE: begin
            q_push = !q_full;
            if (!q_full) begin
               state_in = tpc_pkg::FRONT_IDLE;
            end
         end
         default: begin
            state_in = tpc_pkg::FRONT_IDLE;
         end
      endcase
   end
endmodule
`default_nettype wire

// ===== rtl/tpc_div.sv =====
// Radix-2 restoring divider on magnitudes, one quotient bit per cycle.
// Depends on tpc_pkg for widths and the result struct.
`default_nettype none
module tpc_div (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire logic                                  start,
   input  wire logic signed [tpc_pkg::MOM_W-1:0]      dividend,
   input  wire logic signed [tpc_pkg::DIVISOR_W-1:0]  divisor,
   output tpc_pkg::div_result_type                    result
);
   localparam int MW = tpc_pkg::MOM_W;
   localparam int DW = tpc_pkg::DIVISOR_W;

   logic                             busy_ff, done_ff, neg_ff;
   logic [tpc_pkg::DIV_CNT_W-1:0]    cnt_ff;
   logic [MW-1:0]                    q_ff;
   logic [DW-1:0]                    rem_ff, dvs_ff;
   logic [DW:0]                      rem_sh;
   logic                             ge;

   assign rem_sh = {rem_ff, q_ff[MW-1]};
   assign ge     = (rem_sh >= {1'b0, dvs_ff});

   assign result.done      = done_ff;
   assign result.neg       = neg_ff;
   assign result.magnitude = q_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
         end else if (busy_ff && cnt_ff == tpc_pkg::DIV_CNT_W'(MW - 1)) begin
            busy_ff <= 1'b0;
            done_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         q_ff   <= dividend[MW-1] ? (~dividend + 1'b1) : dividend;
         dvs_ff <= divisor[DW-1] ? (~divisor + 1'b1) : divisor;
         neg_ff <= dividend[MW-1] ^ divisor[DW-1];
         rem_ff <= '0;
         cnt_ff <= '0;
      end else if (busy_ff) begin
         rem_ff <= ge ? DW'(rem_sh - {1'b0, dvs_ff}) : rem_sh[DW-1:0];
         q_ff   <= {q_ff[MW-2:0], ge};
         cnt_ff <= cnt_ff + 1'b1;
      end
   end
endmodule
`default_nettype wire

// ===== rtl/tpc_back.sv =====
// Back end: shoelace accumulation per point and centroid division per sample.
// Depends on tpc_pkg and tpc_div; drains the point queue, fills the result queue.
`default_nettype none
module tpc_back #(
   parameter int COORD_WIDTH = 20
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 q_empty,
   output logic                      q_pop,
   input  wire logic [2*COORD_WIDTH+2:0] q_data,
   input  wire logic                 rsp_full,
   output logic                      rsp_push,
   output tpc_pkg::rsp_payload_type  rsp_data
);
   localparam int W    = COORD_WIDTH;
   localparam int CW   = 2 * W + 1;
   localparam int PW   = 3 * W + 2;
   localparam int AW   = tpc_pkg::AREA_W;
   localparam int MW   = tpc_pkg::MOM_W;
   localparam int OW   = tpc_pkg::OUT_W;
   localparam int ASW  = ((CW > AW) ? CW : AW) + 1;
   localparam int EW   = ((PW > MW) ? PW : MW) + 1;
   localparam logic signed [ASW-1:0] AREA_HI = (ASW'(1) <<< (AW - 1)) - ASW'(1);
   localparam logic signed [ASW-1:0] AREA_LO = -AREA_HI - ASW'(1);
   localparam logic signed [EW-1:0]  MOM_HI  = (EW'(1) <<< (MW - 1)) - EW'(1);
   localparam logic signed [EW-1:0]  MOM_LO  = -MOM_HI - EW'(1);
   localparam logic [MW-1:0]         Q_LIM   = MW'(1) << (W - 1);

   tpc_pkg::back_state_type state_ff, state_in;
   logic signed [W-1:0]  pt_x_ff, pt_y_ff, prev_x_ff, prev_y_ff;
   logic                 se_ff, seg_ff, have_prev_ff, sat_ff, degen_ff;
   logic signed [2*W-1:0] cross_a_ff, cross_b_ff;
   logic signed [W:0]    sum_x_ff, sum_y_ff;
   logic signed [CW-1:0] c_ff, c_in;
   logic signed [PW-1:0] mp_x_ff, mp_y_ff;
   logic signed [AW-1:0] area_ff;
   logic signed [MW-1:0] mom_x_ff, mom_y_ff;
   logic signed [OW-1:0] cx_ff, cy_ff;
   logic signed [ASW-1:0] area_wide;
   logic                 area_sat;
   logic signed [AW-1:0] area_clamped;
   logic [MW:0]          acc_x, acc_y;
   logic [OW:0]          q_out;
   logic                 div_start;
   logic signed [MW-1:0] div_dividend;
   logic signed [tpc_pkg::DIVISOR_W-1:0] div_divisor;
   tpc_pkg::div_result_type div_res;

   // clamp a product to 64 bits, then add with saturation; top bit flags a clamp
   function automatic logic [MW:0] mom_acc(input logic signed [MW-1:0] sum,
                                          input logic signed [PW-1:0] prod);
      logic signed [EW-1:0] p;
      logic signed [MW:0]   s;
      logic                 sat;
      p   = EW'(prod);
      sat = 1'b0;
      if (p > MOM_HI) begin
         p   = MOM_HI;
         sat = 1'b1;
      end else if (p < MOM_LO) begin
         p   = MOM_LO;
         sat = 1'b1;
      end
      s = (MW + 1)'(sum) + (MW + 1)'(signed'(p[MW-1:0]));
      if (s[MW] != s[MW-1]) begin
         sat = 1'b1;
         s[MW-1:0] = s[MW] ? {1'b1, {(MW - 1){1'b0}}} : {1'b0, {(MW - 1){1'b1}}};
      end
      return {sat, s[MW-1:0]};
   endfunction

   // clamp a quotient magnitude to the coordinate range, keep the output bits
   function automatic logic [OW:0] quot_clamp(input logic neg, input logic [MW-1:0] mag);
      logic [MW-1:0] v;
      logic          sat;
      sat = 1'b0;
      if (!neg && mag > Q_LIM - 1'b1) begin
         v   = Q_LIM - 1'b1;
         sat = 1'b1;
      end else if (neg && mag > Q_LIM) begin
         v   = -Q_LIM;
         sat = 1'b1;
      end else begin
         v = neg ? -mag : mag;
      end
      return {sat, v[OW-1:0]};
   endfunction

   assign c_in      = CW'(cross_a_ff) - CW'(cross_b_ff);
   assign area_wide = ASW'(area_ff) + ASW'(c_in);
   assign area_sat  = (area_wide > AREA_HI) || (area_wide < AREA_LO);
   assign area_clamped = (area_wide > AREA_HI) ? AREA_HI[AW-1:0] :
                         (area_wide < AREA_LO) ? AREA_LO[AW-1:0] : area_wide[AW-1:0];
   assign acc_x     = mom_acc(mom_x_ff, mp_x_ff);
   assign acc_y     = mom_acc(mom_y_ff, mp_y_ff);
   assign q_out     = quot_clamp(div_res.neg, div_res.magnitude);

   assign div_dividend = (state_ff == tpc_pkg::BACK_DIVY) ? mom_y_ff : mom_x_ff;
   assign div_divisor  = (tpc_pkg::DIVISOR_W'(area_ff) <<< 1) + tpc_pkg::DIVISOR_W'(area_ff);

   tpc_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .result   (div_res)
   );

   assign rsp_data.centroid_x = cx_ff;
   assign rsp_data.centroid_y = cy_ff;
   assign rsp_data.twice_area = area_ff;
   assign rsp_data.degenerate = degen_ff;
   assign rsp_data.saturated  = sat_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= tpc_pkg::BACK_IDLE;
         have_prev_ff <= 1'b0;
         sat_ff       <= 1'b0;
         area_ff      <= '0;
         mom_x_ff     <= '0;
         mom_y_ff     <= '0;
         prev_x_ff    <= '0;
         prev_y_ff    <= '0;
      end else begin
         state_ff <= state_in;
         case (state_ff)
            tpc_pkg::BACK_IDLE: begin
               if (!q_empty) begin
                  sat_ff <= sat_ff | q_data[2*W];
               end
            end
            tpc_pkg::BACK_AREA: begin
               if (seg_ff) begin
                  area_ff <= area_clamped;
                  sat_ff  <= sat_ff | area_sat;
               end
            end
            tpc_pkg::BACK_ACC: begin
               if (seg_ff) begin
                  mom_x_ff <= acc_x[MW-1:0];
                  mom_y_ff <= acc_y[MW-1:0];
                  sat_ff   <= sat_ff | acc_x[MW] | acc_y[MW];
               end
               prev_x_ff    <= pt_x_ff;
               prev_y_ff    <= pt_y_ff;
               have_prev_ff <= 1'b1;
            end
            tpc_pkg::BACK_WAITX, tpc_pkg::BACK_WAITY: begin
               if (div_res.done) begin
                  sat_ff <= sat_ff | q_out[OW];
               end
            end
            tpc_pkg::BACK_OUT: begin
               if (!rsp_full) begin
                  have_prev_ff <= 1'b0;
                  sat_ff       <= 1'b0;
                  area_ff      <= '0;
                  mom_x_ff     <= '0;
                  mom_y_ff     <= '0;
               end
            end
            default: begin
            end
         endcase
      end
   end

   // datapath registers without reset
   always_ff @(posedge clock) begin
      if (state_ff == tpc_pkg::BACK_IDLE && !q_empty) begin
         pt_x_ff <= q_data[W-1:0];
         pt_y_ff <= q_data[2*W-1:W];
         se_ff   <= q_data[2*W+1];
         seg_ff  <= have_prev_ff && !q_data[2*W+2];
      end
      if (state_ff == tpc_pkg::BACK_CROSS) begin
         cross_a_ff <= prev_x_ff * pt_y_ff;
         cross_b_ff <= pt_x_ff * prev_y_ff;
         sum_x_ff   <= (W + 1)'(prev_x_ff) + (W + 1)'(pt_x_ff);
         sum_y_ff   <= (W + 1)'(prev_y_ff) + (W + 1)'(pt_y_ff);
      end
      if (state_ff == tpc_pkg::BACK_AREA) begin
         c_ff <= c_in;
      end
      if (state_ff == tpc_pkg::BACK_MOM) begin
         mp_x_ff <= c_ff * sum_x_ff;
         mp_y_ff <= c_ff * sum_y_ff;
      end
      if (state_ff == tpc_pkg::BACK_DIVX) begin
         degen_ff <= (area_ff == '0);
         cx_ff    <= '0;
         cy_ff    <= '0;
      end
      if (state_ff == tpc_pkg::BACK_WAITX && div_res.done) begin
         cx_ff <= q_out[OW-1:0];
      end
      if (state_ff == tpc_pkg::BACK_WAITY && div_res.done) begin
         cy_ff <= q_out[OW-1:0];
      end
   end

   always_comb begin
      state_in  = state_ff;
      q_pop     = 1'b0;
      rsp_push  = 1'b0;
      div_start = 1'b0;
      case (state_ff)
         tpc_pkg::BACK_IDLE: begin
            q_pop = !q_empty;
            if (!q_empty) begin
               state_in = tpc_pkg::BACK_CROSS;
            end
         end
         tpc_pkg::BACK_CROSS: state_in = tpc_pkg::BACK_AREA;
         tpc_pkg::BACK_AREA:  state_in = tpc_pkg::BACK_MOM;
         tpc_pkg::BACK_MOM:   state_in = tpc_pkg::BACK_ACC;
         tpc_pkg::BACK_ACC: begin
            state_in = se_ff ? tpc_pkg::BACK_DIVX : tpc_pkg::BACK_IDLE;
         end
         tpc_pkg::BACK_DIVX: begin
            if (area_ff == '0) begin
               state_in = tpc_pkg::BACK_OUT;
            end else begin
               div_start = 1'b1;
               state_in  = tpc_pkg::BACK_WAITX;
            end
         end
         tpc_pkg::BACK_WAITX: begin
            if (div_res.done) begin
               state_in = tpc_pkg::BACK_DIVY;
            end
         end
         tpc_pkg::BACK_DIVY: begin
            div_start = 1'b1;
            state_in  = tpc_pkg::BACK_WAITY;
         end
         tpc_pkg::BACK_WAITY: begin
            if (div_res.done) begin
               state_in = tpc_pkg::BACK_OUT;
            end
         end
         tpc_pkg::BACK_OUT: begin
            rsp_push = !rsp_full;
            if (!rsp_full) begin
               state_in = tpc_pkg::BACK_IDLE;
            end
         end
         default: state_in = tpc_pkg::BACK_IDLE;
      endcase
   end
endmodule
`default_nettype wire

// ===== rtl/toolpath_point_transform_centroid.sv =====
// Top level of the toolpath point transform and shoelace centroid block.
// Depends on tpc_pkg, tpc_fifo, tpc_front and tpc_back (which holds tpc_div).
//
// Raw points enter as queue pushes; each is scaled by its Q8.24 factor, rounded
// to Q12.8 mm, offset by the origin and clamped. A front stage does the transform
// in its idle, multiply and done states, one point at a time, and hands points
// through a short queue to a back sequencer, which adds the shoelace cross term
// and both moment terms in its cross, area, moment and accumulate steps; the
// back sequencer sets the sustained rate. On a sample's last point the back end
// also runs the centroid division, x then y, on a shared one-bit-per-cycle
// divider, and skips the division when the area is zero. The front keeps
// accepting points while the back end divides, until the point queue fills.
// Results go into a two-entry result queue, so a single waiting result does not
// hold up the back end; with both entries taken the back end waits, the point
// queue fills and req_full rises. Configuration registers are written through
// the csr channel, which is always ready; write them only while the block is
// idle.
`default_nettype none
module toolpath_point_transform_centroid #(
   parameter int COORD_WIDTH     = 20,
   parameter int SCALE_FRAC_BITS = 24,
   parameter int QUEUE_DEPTH     = 4
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   // point channel
   input  wire logic                              req_push,
   output logic                                   req_full,
   input  wire tpc_pkg::req_payload_type          req_data,
   // result channel
   output logic                                   rsp_empty,
   input  wire logic                              rsp_pop,
   output tpc_pkg::rsp_payload_type               rsp_data,
   // register writes
   input  wire logic                              csr_valid,
   output logic                                   csr_ready,
   input  wire logic [tpc_pkg::CSR_IDX_W-1:0]     csr_index,
   input  wire logic [tpc_pkg::CSR_DATA_W-1:0]    csr_data
);
   localparam int PT_W  = 2 * COORD_WIDTH + 3;
   localparam int RSP_W = $bits(tpc_pkg::rsp_payload_type);

   tpc_pkg::cfg_type cfg_ff;
   logic             pq_push, pq_full, pq_pop, pq_empty;
   logic [PT_W-1:0]  pq_din, pq_dout;
   logic             rq_push, rq_full;
   tpc_pkg::rsp_payload_type rq_din;
   logic [RSP_W-1:0] rq_dout;

   assign csr_ready = 1'b1;

   // configuration registers; out-of-range indexes are dropped
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.scale_x  <= tpc_pkg::SCALE_W'(64'd1 << SCALE_FRAC_BITS);
         cfg_ff.scale_y  <= tpc_pkg::SCALE_W'(64'd1 << SCALE_FRAC_BITS);
         cfg_ff.origin_x <= '0;
         cfg_ff.origin_y <= '0;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            tpc_pkg::CSR_SCALE_X:  cfg_ff.scale_x  <= csr_data;
            tpc_pkg::CSR_SCALE_Y:  cfg_ff.scale_y  <= csr_data;
            tpc_pkg::CSR_ORIGIN_X: cfg_ff.origin_x <= csr_data[tpc_pkg::ORIGIN_W-1:0];
            tpc_pkg::CSR_ORIGIN_Y: cfg_ff.origin_y <= csr_data[tpc_pkg::ORIGIN_W-1:0];
            default: begin
            end
         endcase
      end
   end

   tpc_front #(
      .COORD_WIDTH     (COORD_WIDTH),
      .SCALE_FRAC_BITS (SCALE_FRAC_BITS)
   ) u_front (
      .clock    (clock),
      .reset    (reset),
      .req_push (req_push),
      .req_full (req_full),
      .req_data (req_data),
      .cfg      (cfg_ff),
      .q_full   (pq_full),
      .q_push   (pq_push),
      .q_data   (pq_din)
   );

   // transformed points between front and back
   tpc_fifo #(
      .WIDTH (PT_W),
      .DEPTH (QUEUE_DEPTH)
   ) u_point_q (
      .clock (clock),
      .reset (reset),
      .push  (pq_push),
      .din   (pq_din),
      .full  (pq_full),
      .pop   (pq_pop),
      .dout  (pq_dout),
      .empty (pq_empty)
   );

   tpc_back #(
      .COORD_WIDTH (COORD_WIDTH)
   ) u_back (
      .clock    (clock),
      .reset    (reset),
      .q_empty  (pq_empty),
      .q_pop    (pq_pop),
      .q_data   (pq_dout),
      .rsp_full (rq_full),
      .rsp_push (rq_push),
      .rsp_data (rq_din)
   );

   // finished results waiting to be taken
   tpc_fifo #(
      .WIDTH (RSP_W),
      .DEPTH (2)
   ) u_rsp_q (
      .clock (clock),
      .reset (reset),
      .push  (rq_push),
      .din   (rq_din),
      .full  (rq_full),
      .pop   (rsp_pop),
      .dout  (rq_dout),
      .empty (rsp_empty)
   );

   assign rsp_data = tpc_pkg::rsp_payload_type'(rq_dout);

   // back end never pushes a result into a full queue
   a_rsp_no_overflow: assert property (@(posedge clock) disable iff (reset)
      rq_push |-> !rq_full)
      else $error("result pushed into full queue");

   // the front takes one point at a time
   a_front_busy: assert property (@(posedge clock) disable iff (reset)
      (req_push && !req_full) |=> req_full)
      else $error("front accepted back-to-back points");

   // a zero-area result carries a zero centroid
   a_degen_zero: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_data.degenerate) |->
         (rsp_data.centroid_x == '0 && rsp_data.centroid_y == '0))
      else $error("degenerate result with nonzero centroid");

endmodule
`default_nettype wire

// ===== tb/toolpath_point_transform_centroid_test.sv =====
// Self-checking testbench for toolpath_point_transform_centroid: point transform,
// shoelace sums and centroid division, checked against a built-in predictor.
// Depends on tpc_pkg and the block's rtl; needs nothing else.
`default_nettype none
module toolpath_point_transform_centroid_test;

   // Index that decodes to no register: writes to it must be ignored.
   localparam logic [tpc_pkg::CSR_IDX_W-1:0] CSR_UNUSED = tpc_pkg::CSR_IDX_W'(15);
   localparam longint HALF_LSB  = 64'sd32768;   // rounding bias before the Q12.8 drop
   localparam int     FRAC_DROP = 16;           // 24 scale fraction bits down to 8
   localparam int     SETTLE    = 400;          // covers two divides plus queued points
   localparam longint COORD_MAX = 64'sd524287;
   localparam longint COORD_MIN = -64'sd524288;
   localparam int COORD_WIDTH_TB = tpc_pkg::OUT_W;

   logic            clock = 1'b0;
   logic            reset = 1'b1;
   logic            req_push = 1'b0;
   logic            req_full;
   tpc_pkg::req_payload_type req_data = '0;
   logic            rsp_empty;
   logic            rsp_pop = 1'b0;
   tpc_pkg::rsp_payload_type rsp_data;
   logic                  csr_valid = 1'b0;
   logic                  csr_ready;
   logic [tpc_pkg::CSR_IDX_W-1:0]  csr_index = '0;
   logic [tpc_pkg::CSR_DATA_W-1:0] csr_data = '0;

   toolpath_point_transform_centroid DUT (
      .clock(clock), .reset(reset),
      .req_push(req_push), .req_full(req_full), .req_data(req_data),
      .rsp_empty(rsp_empty), .rsp_pop(rsp_pop), .rsp_data(rsp_data),
      .csr_valid(csr_valid), .csr_ready(csr_ready),
      .csr_index(csr_index), .csr_data(csr_data)
   );

   always #5 clock = ~clock;

   // Shadow registers and accumulation state of the predictor.
   logic [31:0] mirror_scale_x = 32'h0100_0000, mirror_scale_y = 32'h0100_0000;
   longint      mirror_origin_x = 0, mirror_origin_y = 0;
   longint      last_x = 0, last_y = 0;
   bit          last_valid = 0;
   longint      area_acc = 0, mom_x_acc = 0, mom_y_acc = 0;
   bit          clamp_seen = 0;

   tpc_pkg::rsp_payload_type pending_centroids[$];
   int error_count = 0;
   int points_sent = 0;
   int centroids_seen = 0;
   int hold_cycles = 0;   // receiver hold-off, picked up by the receiver process

   function automatic longint clamp_bits(longint v, int w, inout bit sat);
      longint hi, lo;
      hi = (64'sd1 <<< (w - 1)) - 1;
      lo = -hi - 1;
      if (v > hi) begin sat = 1; return hi; end
      if (v < lo) begin sat = 1; return lo; end
      return v;
   endfunction

   function automatic longint add_clamped(longint a, longint b, inout bit sat);
      logic signed [64:0] s;
      s = 65'(a) + 65'(b);
      if (s > 65'sh0_7FFF_FFFF_FFFF_FFFF) begin sat = 1; return 64'sh7FFF_FFFF_FFFF_FFFF; end
      if (s < -65'sh0_8000_0000_0000_0000) begin sat = 1; return 64'sh8000_0000_0000_0000; end
      return longint'(s);
   endfunction

   function automatic longint mul_clamped(longint a, longint b, inout bit sat);
      logic signed [127:0] pa, pb, pr;
      pa = a;
      pb = b;
      pr = pa * pb;
      if (pr > 128'sh7FFF_FFFF_FFFF_FFFF) begin sat = 1; return 64'sh7FFF_FFFF_FFFF_FFFF; end
      if (pr < -128'sh8000_0000_0000_0000) begin sat = 1; return 64'sh8000_0000_0000_0000; end
      return longint'(pr);
   endfunction

   // raw * Q8.24 scale, round half up to Q12.8, add origin, clamp
   function automatic longint scale_point(logic signed [31:0] raw, logic [31:0] scale,
                                          longint org, inout bit sat);
      longint p;
      p = longint'(raw) * longint'({32'b0, scale});
      return clamp_bits(((p + HALF_LSB) >>> FRAC_DROP) + org, COORD_WIDTH_TB, sat);
   endfunction

   function automatic longint centroid_of(longint moment, longint area, inout bit sat);
      return clamp_bits(moment / (3 * area), COORD_WIDTH_TB, sat);
   endfunction

   // Accepted point: update the sums; queue a centroid on a sample end.
   task automatic predict_point(tpc_pkg::req_payload_type pt);
      bit sat;
      longint x, y, c;
      tpc_pkg::rsp_payload_type r;
      sat = clamp_seen;
      x = scale_point(pt.raw_x, mirror_scale_x, mirror_origin_x, sat);
      y = scale_point(pt.raw_y, mirror_scale_y, mirror_origin_y, sat);
      if (last_valid && !pt.line_start) begin
         c = last_x * y - x * last_y;
         area_acc  = clamp_bits(area_acc + c, tpc_pkg::AREA_W, sat);
         mom_x_acc = add_clamped(mom_x_acc, mul_clamped(c, last_x + x, sat), sat);
         mom_y_acc = add_clamped(mom_y_acc, mul_clamped(c, last_y + y, sat), sat);
      end
      last_x = x;
      last_y = y;
      last_valid = 1;
      clamp_seen = sat;
      if (pt.sample_end) begin
         r = '0;
         r.degenerate = (area_acc == 0);
         if (!r.degenerate) begin
            r.centroid_x = tpc_pkg::OUT_W'(centroid_of(mom_x_acc, area_acc, sat));
            r.centroid_y = tpc_pkg::OUT_W'(centroid_of(mom_y_acc, area_acc, sat));
         end
         r.twice_area = tpc_pkg::AREA_W'(area_acc);
         r.saturated  = sat;
         pending_centroids.push_back(r);
         last_valid = 0;
         area_acc = 0;
         mom_x_acc = 0;
         mom_y_acc = 0;
         clamp_seen = 0;
      end
   endtask

   task automatic report(string what, longint got, longint want);
      error_count++;
      $display("mismatch %s: got %0h want %0h at %0t", what, got, want, $time);
   endtask

   // One point transaction; req_push stays high if the next one follows at once.
   task automatic send_point(logic signed [31:0] rx, logic signed [31:0] ry,
                             bit ls, bit se, bit no_gap = 0);
      int gap;
      tpc_pkg::req_payload_type pt;
      gap = no_gap ? 0 : $urandom_range(0, 3);
      pt.raw_x = rx;
      pt.raw_y = ry;
      pt.line_start = ls;
      pt.sample_end = se;
      if (gap > 0) begin
         req_push <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_push <= 1'b1;
      req_data <= pt;
      forever begin
         @(negedge clock);
         if (!req_full) break;
         @(posedge clock);
      end
      @(posedge clock);
      predict_point(pt);
      points_sent++;
   endtask

   task automatic write_reg(logic [tpc_pkg::CSR_IDX_W-1:0] idx, logic [31:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      forever begin
         @(negedge clock);
         if (csr_ready) break;
         @(posedge clock);
      end
      @(posedge clock);
      case (idx)
         tpc_pkg::CSR_SCALE_X:  mirror_scale_x = val;
         tpc_pkg::CSR_SCALE_Y:  mirror_scale_y = val;
         tpc_pkg::CSR_ORIGIN_X:
            mirror_origin_x = longint'(signed'(val[tpc_pkg::ORIGIN_W-1:0]));
         tpc_pkg::CSR_ORIGIN_Y:
            mirror_origin_y = longint'(signed'(val[tpc_pkg::ORIGIN_W-1:0]));
         default: ;
      endcase
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   // Stop offering points, drain every expected centroid, then let the pipe settle.
   task automatic drain;
      req_push <= 1'b0;
      while (pending_centroids.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic set_transform(logic [31:0] sx, logic [31:0] sy,
                                logic [31:0] ox, logic [31:0] oy);
      drain();
      write_reg(tpc_pkg::CSR_SCALE_X, sx);
      write_reg(tpc_pkg::CSR_SCALE_Y, sy);
      write_reg(tpc_pkg::CSR_ORIGIN_X, ox);
      write_reg(tpc_pkg::CSR_ORIGIN_Y, oy);
   endtask

   function automatic logic [31:0] pick_raw();
      case ($urandom_range(0, 3))
         0: return 32'($urandom_range(0, 8191)) - 32'd4096;
         1: return $urandom;
         2: case ($urandom_range(0, 3))
               0: return 32'h7FFF_FFFF;
               1: return 32'h8000_0000;
               2: return 32'h0;
               default: return 32'hFFFF_FFFF;
            endcase
         default: return 32'($urandom_range(0, 2097151)) - 32'd1048576;
      endcase
   endfunction

   // Receiver: random pop gaps, plus a long hold-off when asked.
   initial begin : centroid_checker
      int gap;
      tpc_pkg::rsp_payload_type got, want;
      forever begin
         gap = $urandom_range(0, 3);
         if (hold_cycles > 0) begin
            gap = hold_cycles;
            hold_cycles = 0;
         end
         if (gap > 0) begin
            rsp_pop <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_pop <= 1'b1;
         forever begin
            @(negedge clock);
            if (!rsp_empty) break;
            @(posedge clock);
         end
         got = rsp_data;
         @(posedge clock);
         centroids_seen++;
         if (pending_centroids.size() == 0) begin
            report("unexpected result transaction", got.twice_area, 0);
         end else begin
            want = pending_centroids.pop_front();
            if (got.centroid_x !== want.centroid_x)
               report("centroid_x", got.centroid_x, want.centroid_x);
            if (got.centroid_y !== want.centroid_y)
               report("centroid_y", got.centroid_y, want.centroid_y);
            if (got.twice_area !== want.twice_area)
               report("twice_area", got.twice_area, want.twice_area);
            if (got.degenerate !== want.degenerate)
               report("degenerate", got.degenerate, want.degenerate);
            if (got.saturated !== want.saturated)
               report("saturated", got.saturated, want.saturated);
         end
      end
   end

   // Small shapes, lone points, broken lines and ignored register index.
   task automatic test_directed_cases;
      send_point(0, 0, 1, 0);
      send_point(4, 0, 0, 0);
      send_point(0, 3, 0, 1);               // triangle
      send_point(7, -9, 0, 1);              // single point: zero area
      send_point(0, 0, 0, 0);
      send_point(10, 0, 0, 0);
      send_point(10, 10, 1, 0);             // line break drops this segment
      send_point(0, 10, 0, 1);
      send_point(32'h7FFF_FFFF, 32'h8000_0000, 1, 0);   // clamps both coords
      send_point(32'h8000_0000, 32'h7FFF_FFFF, 0, 1);
      send_point(-5, -5, 0, 0);
      send_point(5, -5, 0, 0);
      send_point(5, 5, 0, 0);
      send_point(-5, 5, 0, 0);
      send_point(-5, -5, 0, 1);             // counterclockwise square
      drain();
      write_reg(CSR_UNUSED, 32'hDEAD_BEEF);
      send_point(1, 2, 0, 0);
      send_point(3, 1, 0, 1);
   endtask

   // Half-LSB ties round toward plus infinity; also extreme scale and origin.
   task automatic test_rounding_ties;
      set_transform(32'h0000_8000, 32'h0001_8000, 32'h0007_FFFF, 32'h0008_0000);
      send_point(1, -1, 0, 0);
      send_point(-1, 1, 0, 0);
      send_point(3, -3, 0, 1);
      set_transform(32'hFFFF_FFFF, 32'h0, 32'hFFFF_FFFF, 32'h0);
      send_point(32'h8000_0000, 32'h7FFF_FFFF, 0, 0);
      send_point(1, 0, 0, 0);
      send_point(-1, 5, 0, 1);
   endtask

   // Repeated thin triangle at full coordinate range pushes the x moment past 64 bits.
   task automatic test_moment_overflow;
      set_transform(32'h0100_0000, 32'h0100_0000, 32'h0, 32'h0);
      send_point(0, 0, 1, 0);
      repeat (20) begin
         send_point(1 << 20, 1 << 20, 0, 0);
         send_point(1 << 20, -(1 << 20), 0, 0);
         send_point(0, 0, 0, 0);
      end
      send_point(0, 0, 0, 1);
   endtask

   // Corner square loop at full range: the area sum clamps at 48 bits.
   task automatic test_area_overflow;
      send_point(1 << 20, 1 << 20, 1, 0);
      repeat (66) begin
         send_point(-(1 << 20), 1 << 20, 0, 0, 1);
         send_point(-(1 << 20), -(1 << 20), 0, 0, 1);
         send_point(1 << 20, -(1 << 20), 0, 0, 1);
         send_point(1 << 20, 1 << 20, 0, 0, 1);
      end
      send_point(0, 0, 0, 1);
   endtask

   // Receiver stalls for a long stretch while points keep coming.
   task automatic test_backpressure;
      drain();
      hold_cycles = 1500;
      repeat (24) send_point(pick_raw(), pick_raw(), 0, 1, 1);
   endtask

   // Random samples under several transform settings.
   task automatic test_random_settings;
      int n, len;
      for (int phase = 0; phase < 5; phase++) begin
         case (phase)
            0: set_transform(32'h0100_0000, 32'h0100_0000, 32'h0, 32'h0);
            1: set_transform($urandom, $urandom, $urandom, $urandom);
            2: set_transform(32'h0000_4000, 32'h0002_0000, 32'h0000_1234, 32'hFFFF_F000);
            3: set_transform(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0008_0000, 32'h0007_FFFF);
            default: set_transform(32'($urandom_range(0, 33554432)),
                                   32'($urandom_range(0, 33554432)), $urandom, $urandom);
         endcase
         n = 0;
         while (n < 130) begin
            len = $urandom_range(1, 8);
            for (int k = 0; k < len; k++) begin
               if ($urandom_range(0, 9) == 0)          // stray noise point
                  send_point(pick_raw(), pick_raw(), 1'($urandom_range(0, 1)), 0);
               send_point(pick_raw(), pick_raw(),
                          (k == 0) ? 1'($urandom_range(0, 1)) : ($urandom_range(0, 6) == 0),
                          k == len - 1);
               n++;
            end
         end
      end
   endtask

   initial begin : limit
      #10_000_000;
      $display("toolpath_point_transform_centroid_test NOT OK");
      $finish;
   end

   initial begin : run
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed_cases();
      test_rounding_ties();
      test_moment_overflow();
      test_area_overflow();
      test_backpressure();
      test_random_settings();
      drain();
      $display("covered %0d points and %0d centroid transactions", points_sent, centroids_seen);
      $display("incl. rounding ties, coordinate, area and moment clamps, long pop stall");
      if (error_count == 0 && pending_centroids.size() == 0) begin
         $display("toolpath_point_transform_centroid_test OK");
      end else begin
         $display("toolpath_point_transform_centroid_test NOT OK");
      end
      $finish;
   end
endmodule
`default_nettype wire
